@@ hdl/lkv_pkg.sv @@
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared codes and types for the LRU key-value cache core.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int CAP_BITS = 7;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;

  typedef enum logic [1:0] {
    ACT_GET = 2'd0,
    ACT_PUT = 2'd1,
    ACT_DEL = 2'd2
  } action_t;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_MISS = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_RESULT
  } state_t;

  typedef enum logic {
    UPD_TOUCH,
    UPD_DELETE
  } upd_t;

endpackage

@@ hdl/lkv_if.sv @@
// ----------------------------------------------------------------------------
// lkv interfaces
// Request, response and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface lkv_req_if #(parameter int KEY_BITS = 64, parameter int VALUE_BITS = 32);
  logic                  valid;
  logic                  ready;
  logic [1:0]            action;
  logic [KEY_BITS-1:0]   lookup_key;
  logic [VALUE_BITS-1:0] write_value;
  modport source (output valid, action, lookup_key, write_value, input ready);
  modport sink   (input valid, action, lookup_key, write_value, output ready);
endinterface

interface lkv_rsp_if #(parameter int VALUE_BITS = 32);
  logic                  valid;
  logic                  ready;
  logic                  status;
  logic [VALUE_BITS-1:0] read_value;
  modport source (output valid, status, read_value, input ready);
  modport sink   (input valid, status, read_value, output ready);
endinterface

interface lkv_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ hdl/lkv_entry_ram.sv @@
// ----------------------------------------------------------------------------
// lkv_entry_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lkv_entry_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 103
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/lkv_ctrl.sv @@
// ----------------------------------------------------------------------------
// lkv_ctrl
// Sweep sequencer: clears the entry store after reset, scans it, decides, then rewrites ranks if needed.
// ----------------------------------------------------------------------------
module lkv_ctrl #(
  parameter int ENTRIES    = 64,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 32,
  parameter int IDX_BITS   = $clog2(ENTRIES),
  parameter int CNT_BITS   = $clog2(ENTRIES + 1),
  parameter int WIDTH      = 1 + IDX_BITS + VALUE_BITS + KEY_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  lkv_req_if.sink                       req,
  lkv_rsp_if.source                     rsp,
  input  logic [lkv_pkg::CAP_BITS-1:0]  capacity,
  output logic                          empty,
  output logic                          ram_wr_en,
  output logic [IDX_BITS-1:0]           ram_wr_addr,
  output logic [WIDTH-1:0]              ram_wr_data,
  output logic [IDX_BITS-1:0]           ram_rd_addr,
  input  logic [WIDTH-1:0]              ram_rd_data
);
  import lkv_pkg::*;

  localparam int CMP_BITS = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;
  localparam int VAL_LO   = KEY_BITS;
  localparam int RANK_LO  = KEY_BITS + VALUE_BITS;
  localparam int VLD_BIT  = KEY_BITS + VALUE_BITS + IDX_BITS;

  state_t state, state_next;

  logic [IDX_BITS:0]     cnt;
  logic                  pend_vld;
  logic [IDX_BITS-1:0]   pend_idx;
  logic [CNT_BITS-1:0]   count;

  logic [1:0]            req_action;
  logic [KEY_BITS-1:0]   req_key;
  logic [VALUE_BITS-1:0] req_val;

  logic                  hit_f, free_f;
  logic [IDX_BITS-1:0]   hit_idx, free_idx, vict_idx;
  logic [IDX_BITS-1:0]   hit_rank;
  logic [VALUE_BITS-1:0] hit_val;

  upd_t                  upd_mode;
  logic [IDX_BITS-1:0]   tgt_idx, tgt_r;
  logic                  tgt_kv;
  logic                  dec_status;
  logic [VALUE_BITS-1:0] dec_value;
  logic                  res_status;
  logic [VALUE_BITS-1:0] res_value;

  logic                  rsp_valid;

  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;
  logic [IDX_BITS-1:0]   rd_rank;
  logic                  rd_valid;

  logic                  req_xfer, sweep_end, issue;
  logic [CMP_BITS-1:0]   eff_cap;
  logic                  full;

  // decision, combinational in ST_DECIDE
  logic                  d_upd;
  upd_t                  d_mode;
  logic [IDX_BITS-1:0]   d_idx, d_r;
  logic                  d_kv, d_status, d_inc, d_dec;
  logic [VALUE_BITS-1:0] d_value;

  logic [WIDTH-1:0]      upd_word;

  assign rd_key   = ram_rd_data[KEY_BITS-1:0];
  assign rd_val   = ram_rd_data[RANK_LO-1:VAL_LO];
  assign rd_rank  = ram_rd_data[VLD_BIT-1:RANK_LO];
  assign rd_valid = ram_rd_data[VLD_BIT];

  assign req.ready  = (state == ST_IDLE);
  assign req_xfer   = req.valid && req.ready;
  assign empty      = (count == '0);
  assign sweep_end  = (cnt == (IDX_BITS+1)'(ENTRIES)) && !pend_vld;
  assign issue      = (state == ST_SCAN || state == ST_UPDATE) &&
                      (cnt < (IDX_BITS+1)'(ENTRIES));
  assign ram_rd_addr = cnt[IDX_BITS-1:0];

  assign rsp.valid      = rsp_valid;
  assign rsp.status     = res_status;
  assign rsp.read_value = res_value;

  always_comb begin
    if (CMP_BITS'(capacity) == '0) begin
      eff_cap = CMP_BITS'(1);
    end else if (CMP_BITS'(capacity) > CMP_BITS'(ENTRIES)) begin
      eff_cap = CMP_BITS'(ENTRIES);
    end else begin
      eff_cap = CMP_BITS'(capacity);
    end
    full = (CMP_BITS'(count) >= eff_cap) && (count != '0);
  end

  always_comb begin
    d_upd    = 1'b0;
    d_mode   = UPD_TOUCH;
    d_idx    = hit_idx;
    d_r      = hit_rank;
    d_kv     = 1'b0;
    d_status = STATUS_OK;
    d_value  = '0;
    d_inc    = 1'b0;
    d_dec    = 1'b0;
    case (req_action)
      ACT_GET: begin
        if (hit_f) begin
          d_upd   = 1'b1;
          d_value = hit_val;
        end else begin
          d_status = STATUS_MISS;
        end
      end
      ACT_PUT: begin
        d_upd = 1'b1;
        d_kv  = 1'b1;
        if (!hit_f) begin
          if (full) begin
            d_idx = vict_idx;
            d_r   = IDX_BITS'(count - 1'b1);
          end else begin
            d_idx = free_idx;
            d_r   = IDX_BITS'(count);
            d_inc = 1'b1;
          end
        end
      end
      ACT_DEL: begin
        if (hit_f) begin
          d_upd  = 1'b1;
          d_mode = UPD_DELETE;
          d_dec  = 1'b1;
        end else begin
          d_status = STATUS_MISS;
        end
      end
      default: begin
        d_upd = 1'b0;
      end
    endcase
  end

  // rewritten word for the entry arriving during the update sweep
  always_comb begin
    logic [IDX_BITS-1:0] rank;
    rank     = rd_rank;
    upd_word = ram_rd_data;
    if (pend_idx == tgt_idx) begin
      if (upd_mode == UPD_TOUCH) begin
        upd_word[VLD_BIT]              = 1'b1;
        upd_word[VLD_BIT-1:RANK_LO]    = '0;
        if (tgt_kv) begin
          upd_word[KEY_BITS-1:0]       = req_key;
          upd_word[RANK_LO-1:VAL_LO]   = req_val;
        end
      end else begin
        upd_word[VLD_BIT]              = 1'b0;
        upd_word[VLD_BIT-1:RANK_LO]    = '0;
      end
    end else if (rd_valid) begin
      if (upd_mode == UPD_TOUCH && rank < tgt_r) begin
        upd_word[VLD_BIT-1:RANK_LO] = rank + 1'b1;
      end else if (upd_mode == UPD_DELETE && rank > tgt_r) begin
        upd_word[VLD_BIT-1:RANK_LO] = rank - 1'b1;
      end
    end
  end

  always_comb begin
    state_next  = state;
    ram_wr_en   = 1'b0;
    ram_wr_addr = pend_idx;
    ram_wr_data = upd_word;
    case (state)
      ST_CLEAR: begin
        ram_wr_en   = (cnt < (IDX_BITS+1)'(ENTRIES));
        ram_wr_addr = cnt[IDX_BITS-1:0];
        ram_wr_data = '0;
        if (!ram_wr_en) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_xfer) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sweep_end) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_next = d_upd ? ST_UPDATE : ST_RESULT;
      end
      ST_UPDATE: begin
        ram_wr_en = pend_vld;
        if (sweep_end) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!rsp_valid || rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      pend_vld  <= 1'b0;
      count     <= '0;
      rsp_valid <= 1'b0;
      hit_f     <= 1'b0;
      free_f    <= 1'b0;
    end else begin
      pend_vld <= issue;
      if (issue) begin
        pend_idx <= cnt[IDX_BITS-1:0];
      end
      if (issue || (state == ST_CLEAR && ram_wr_en)) begin
        cnt <= cnt + 1'b1;
      end
      // output register loads only once the previous transfer is done
      if (state == ST_RESULT && (!rsp_valid || rsp.ready)) begin
        rsp_valid  <= 1'b1;
        res_status <= dec_status;
        res_value  <= dec_value;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_xfer) begin
            req_action <= req.action;
            req_key    <= req.lookup_key;
            req_val    <= req.write_value;
            hit_f      <= 1'b0;
            free_f     <= 1'b0;
            cnt        <= '0;
          end
        end
        ST_SCAN: begin
          if (pend_vld) begin
            if (rd_valid && rd_key == req_key) begin
              hit_f    <= 1'b1;
              hit_idx  <= pend_idx;
              hit_rank <= rd_rank;
              hit_val  <= rd_val;
            end
            if (!rd_valid && !free_f) begin
              free_f   <= 1'b1;
              free_idx <= pend_idx;
            end
            if (rd_valid && CNT_BITS'(rd_rank) == count - 1'b1) begin
              vict_idx <= pend_idx;
            end
          end
        end
        ST_DECIDE: begin
          upd_mode   <= d_mode;
          tgt_idx    <= d_idx;
          tgt_r      <= d_r;
          tgt_kv     <= d_kv;
          dec_status <= d_status;
          dec_value  <= d_value;
          cnt        <= '0;
          if (d_inc) begin
            count <= count + 1'b1;
          end else if (d_dec) begin
            count <= count - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_xfer_scan: assert property (@(posedge clk) disable iff (rst)
    req_xfer |=> state == ST_SCAN)
    else $error("accepted request did not start a scan");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    CMP_BITS'(count) <= CMP_BITS'(ENTRIES))
    else $error("entry count above depth");
  a_wr_phase: assert property (@(posedge clk) disable iff (rst)
    ram_wr_en |-> (state == ST_UPDATE || state == ST_CLEAR))
    else $error("store written outside a write sweep");
  a_clear_block: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !req.ready)
    else $error("request taken during clearing pass");
`endif

endmodule

@@ hdl/lru_key_value_cache_core.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// Fully associative key-value store with least-recently-used replacement.
//
//   channel  dir  payload                                 transfer
//   req      in   action, lookup_key, write_value         valid && ready
//   rsp      out  status, read_value                      valid && ready
//   cfg      in   data (capacity_in_use)                  valid && ready
//
// A request runs from its transfer through a read sweep that finds hit, free
// slot and victim, a decide state, then a read-modify-write sweep that
// rewrites ranks, and a result state that loads the response register; each
// sweep reads the entries one by one through the single read port.
// Get miss, delete miss and unknown action skip the rewrite sweep.
// After reset a clearing pass blocks requests; cfg is always taken. A
// stalled response holds in its register while the next request is already
// accepted.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core #(
  parameter int ENTRIES    = 64,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  lkv_req_if.sink   req,
  lkv_rsp_if.source rsp,
  lkv_cfg_if.sink   cfg
);
  import lkv_pkg::*;

  localparam int IDX_BITS = $clog2(ENTRIES);
  localparam int WIDTH    = 1 + IDX_BITS + VALUE_BITS + KEY_BITS;

  logic [CAP_BITS-1:0] capacity;
  logic                empty;
  logic                ram_wr_en;
  logic [IDX_BITS-1:0] ram_wr_addr, ram_rd_addr;
  logic [WIDTH-1:0]    ram_wr_data, ram_rd_data;

  assign cfg.ready = 1'b1;

  // capacity changes only while the store is empty
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg.valid && empty) begin
      capacity <= cfg.data;
    end
  end

  lkv_ctrl #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .capacity    (capacity),
    .empty       (empty),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  lkv_entry_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (WIDTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule
